FILE: rtl/tcf_pkg.sv
// package: shared types and constants of the two-class oldest-first queue
`default_nettype none

package tcf_pkg;

   localparam int STAMP_W = 32;

   typedef enum logic [1:0] {
      OP_ENQ     = 2'd0,
      OP_DEQ_ANY = 2'd1,
      OP_DEQ_A   = 2'd2,
      OP_DEQ_B   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   localparam logic CLASS_A = 1'b0;
   localparam logic CLASS_B = 1'b1;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

   typedef struct packed {
      logic has;
      logic full;
   } q_stat_type;

endpackage

`default_nettype wire

FILE: rtl/tcf_req_if.sv
// interface: request channel of the two-class queue
`default_nettype none

interface tcf_req_if
   import tcf_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic               entry_class;
   logic [STAMP_W-1:0] arrival_stamp;

   modport source (output valid, output opcode, output entry_class, output arrival_stamp,
                   input ready);
   modport sink (input valid, input opcode, input entry_class, input arrival_stamp,
                 output ready);
endinterface

`default_nettype wire

FILE: rtl/tcf_rsp_if.sv
// interface: response channel of the two-class queue
`default_nettype none

interface tcf_rsp_if
   import tcf_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic               out_class;
   logic [STAMP_W-1:0] out_stamp;

   modport source (output valid, output status, output out_class, output out_stamp,
                   input ready);
   modport sink (input valid, input status, input out_class, input out_stamp,
                 output ready);
endinterface

`default_nettype wire

FILE: rtl/tcf_queue.sv
// module: one class queue, circular store with a registered head entry
`default_nettype none

module tcf_queue
   import tcf_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire q_ctrl_type         ctrl,
   input  wire logic [STAMP_W-1:0] push_stamp,
   output q_stat_type              stat,
   output logic [STAMP_W-1:0]      front_stamp
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [STAMP_W-1:0] store_mem [DEPTH];

   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop_d_ff, pop_d_in;
   logic [STAMP_W-1:0] front_ff, front_in;
   logic [STAMP_W-1:0] ahead_ff;
   logic [IDX_W-1:0]   head_next;
   logic [IDX_W-1:0]   tail_next;

   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;

   // head entry: the next-to-head read lands in the cycle after a pop
   assign front_stamp = pop_d_ff ? ahead_ff : front_ff;

   assign stat.has  = (count_ff != '0);
   assign stat.full = (count_ff == FULL_CNT);

   always_comb begin
      head_in  = ctrl.pop ? head_next : head_ff;
      tail_in  = ctrl.push ? tail_next : tail_ff;
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         count_in = count_ff - 1'b1;
      end
      pop_d_in = ctrl.pop;
      front_in = (ctrl.push && !stat.has) ? push_stamp : front_stamp;
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         store_mem[tail_ff] <= push_stamp;
      end
      ahead_ff <= store_mem[head_next];
   end

   always_ff @(posedge clock) begin
      front_ff <= front_in;
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         pop_d_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         pop_d_ff <= pop_d_in;
      end
   end

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> stat.has)
      else $error("pop from empty queue");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> !stat.full)
      else $error("push into full queue");

   a_last_pop_empties: assert property (@(posedge clock) disable iff (reset)
      (ctrl.pop && count_ff == CNT_W'(1)) |=> !stat.has)
      else $error("queue not empty after last pop");

endmodule

`default_nettype wire

FILE: rtl/two_class_fifo_oldest_first.sv
// top level: two-class queue with oldest-first dequeue
//
//   channel   dir   handshake      payload
//   req_if    in    valid/ready    opcode, entry_class, arrival_stamp
//   rsp_if    out   valid/ready    status, out_class, out_stamp
//
// one item per cycle sustained while results are taken; a taken item passes through the request
// register and then the result register before its result is offered; the
// registered next-to-head store read in each queue adds no register to that path
// reset empties both queues; store contents are not cleared
// a stalled result holds the request register, which holds req_if.ready low
`default_nettype none

module two_class_fifo_oldest_first
   import tcf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   tcf_req_if.sink   req_if,
   tcf_rsp_if.source rsp_if
);

   logic               s1_valid_ff, s1_valid_in;
   op_type             s1_op_ff;
   logic               s1_class_ff;
   logic [STAMP_W-1:0] s1_stamp_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic               class_ff, class_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;

   logic               advance;
   q_ctrl_type         a_ctrl, b_ctrl;
   q_stat_type         a_stat, b_stat;
   logic [STAMP_W-1:0] a_front, b_front;
   logic               take_b;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;

   assign s1_valid_in  = req_if.ready ? req_if.valid : s1_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   tcf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue_a (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (a_ctrl),
      .push_stamp  (s1_stamp_ff),
      .stat        (a_stat),
      .front_stamp (a_front)
   );

   tcf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue_b (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (b_ctrl),
      .push_stamp  (s1_stamp_ff),
      .stat        (b_stat),
      .front_stamp (b_front)
   );

   // class b only when strictly older, or when class a is empty
   assign take_b = b_stat.has && (!a_stat.has || (b_front < a_front));

   always_comb begin
      a_ctrl    = '0;
      b_ctrl    = '0;
      status_in = ST_EMPTY;
      class_in  = CLASS_A;
      stamp_in  = '0;
      unique case (s1_op_ff)
         OP_ENQ: begin
            if (s1_class_ff == CLASS_B) begin
               status_in   = b_stat.full ? ST_FULL : ST_OK;
               b_ctrl.push = advance && !b_stat.full;
            end else begin
               status_in   = a_stat.full ? ST_FULL : ST_OK;
               a_ctrl.push = advance && !a_stat.full;
            end
         end
         OP_DEQ_ANY: begin
            if (take_b) begin
               status_in  = ST_OK;
               class_in   = CLASS_B;
               stamp_in   = b_front;
               b_ctrl.pop = advance;
            end else if (a_stat.has) begin
               status_in  = ST_OK;
               stamp_in   = a_front;
               a_ctrl.pop = advance;
            end
         end
         OP_DEQ_A: begin
            if (a_stat.has) begin
               status_in  = ST_OK;
               stamp_in   = a_front;
               a_ctrl.pop = advance;
            end
         end
         OP_DEQ_B: begin
            if (b_stat.has) begin
               status_in  = ST_OK;
               class_in   = CLASS_B;
               stamp_in   = b_front;
               b_ctrl.pop = advance;
            end
         end
         default: begin
            status_in = ST_EMPTY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_if.ready) begin
         s1_op_ff    <= op_type'(req_if.opcode);
         s1_class_ff <= req_if.entry_class;
         s1_stamp_ff <= req_if.arrival_stamp;
      end
      if (advance) begin
         status_ff <= status_in;
         class_ff  <= class_in;
         stamp_ff  <= stamp_in;
      end
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = status_ff;
   assign rsp_if.out_class = class_ff;
   assign rsp_if.out_stamp = stamp_ff;

   a_empty_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_EMPTY) |-> (class_ff == CLASS_A && stamp_ff == '0))
      else $error("empty result carries data");

   a_no_pop_when_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |-> !(a_ctrl.pop || b_ctrl.pop || a_ctrl.push || b_ctrl.push))
      else $error("queue state changed while result held");

   a_single_queue_op: assert property (@(posedge clock) disable iff (reset)
      $countones({a_ctrl.pop, b_ctrl.pop, a_ctrl.push, b_ctrl.push}) <= 1)
      else $error("more than one queue operation in a cycle");

endmodule

`default_nettype wire
